// ===== rtl/zero_phase_biquad_filter_macros.svh =====
// -----------------------------------------------------------------------------
// zero_phase_biquad_filter_macros
// assertion helpers for the zero-phase biquad filter
// -----------------------------------------------------------------------------
`ifndef ZERO_PHASE_BIQUAD_FILTER_MACROS_SVH
`define ZERO_PHASE_BIQUAD_FILTER_MACROS_SVH

// implication checked on every clock edge outside reset
`define ZPB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the cycle after the antecedent
`define ZPB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/zpb_pkg.sv =====
// -----------------------------------------------------------------------------
// zpb_pkg
// shared widths, constants and command types of the zero-phase biquad filter
// -----------------------------------------------------------------------------
package zpb_pkg;

   localparam int MAX_LEN_DEF = 64;
   localparam int EDGE_DEF    = 9;
   localparam int SAMPLE_W    = 24;
   localparam int COEF_W      = 32;
   localparam int WORK_W      = 32;
   localparam int DELAY_W     = 48;
   localparam int PROD_SHIFT  = 14;
   localparam int FRAC_BITS   = 16;
   localparam int NUM_REGS    = 7;

   localparam logic [2:0] REG_B0  = 3'd0;
   localparam logic [2:0] REG_B1  = 3'd1;
   localparam logic [2:0] REG_B2  = 3'd2;
   localparam logic [2:0] REG_A1  = 3'd3;
   localparam logic [2:0] REG_A2  = 3'd4;
   localparam logic [2:0] REG_ZI0 = 3'd5;
   localparam logic [2:0] REG_ZI1 = 3'd6;

   // datapath operation codes
   typedef enum logic [3:0] {
      OP_NONE,
      OP_STORE,     // write incoming sample
      OP_SUM,       // accumulate sample for mean
      OP_DIVIDE,    // one step of the mean division
      OP_DEMEAN,    // emit one demeaned sample
      OP_EXTEND,    // build one extended work entry
      OP_INIT,      // load delays from first value
      OP_FILTER,    // one step of the biquad
      OP_EMIT       // emit one filtered sample
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [1:0]  phase;     // sub-step within an operation
      logic [12:0] index;     // sample or work index
      logic [12:0] aux;       // second index
      logic        last;      // marks final emitted result
      logic        first;     // first step of an operation
   } cmd_type;

   typedef struct packed {
      logic        out_busy;  // result register occupied
      logic        div_done;
   } status_type;

   function automatic logic signed [DELAY_W-1:0] sat48(input logic signed [79:0] v);
      logic signed [79:0] hi;
      logic signed [79:0] lo;
      hi = 80'sd140737488355327;
      lo = -80'sd140737488355328;
      if (v > hi) return hi[DELAY_W-1:0];
      if (v < lo) return lo[DELAY_W-1:0];
      return v[DELAY_W-1:0];
   endfunction

   function automatic logic signed [WORK_W-1:0] sat32(input logic signed [79:0] v);
      if (v > 80'sd2147483647) return 32'sh7fffffff;
      if (v < -80'sd2147483648) return 32'sh80000000;
      return v[WORK_W-1:0];
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [79:0] v);
      if (v > 80'sd8388607) return 24'sh7fffff;
      if (v < -80'sd8388608) return 24'sh800000;
      return v[SAMPLE_W-1:0];
   endfunction

endpackage

// ===== rtl/zpb_datapath.sv =====
// -----------------------------------------------------------------------------
// zpb_datapath
// sample and work memories, biquad arithmetic, mean division and result register
// -----------------------------------------------------------------------------
module zpb_datapath #(
   parameter int MAX_LEN = zpb_pkg::MAX_LEN_DEF,
   parameter int EDGE    = zpb_pkg::EDGE_DEF,
   parameter int CNT_W   = $clog2(MAX_LEN + 1),
   parameter int WIDX_W  = $clog2(MAX_LEN + 2 * EDGE)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  zpb_pkg::cmd_type                     cmd,
   output zpb_pkg::status_type                  status,
   input  logic signed [zpb_pkg::SAMPLE_W-1:0]  sample_in,
   input  logic [CNT_W-1:0]                     count,
   input  logic                                 ovf,
   input  logic signed [zpb_pkg::COEF_W-1:0]    regs [zpb_pkg::NUM_REGS],
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [zpb_pkg::SAMPLE_W-1:0]         rsp_tdata,
   output logic [1:0]                           rsp_tuser
);
   import zpb_pkg::*;

   localparam int WORK_LEN = MAX_LEN + 2 * EDGE;
   localparam int SIDX_W   = $clog2(MAX_LEN);
   localparam int SUM_W    = SAMPLE_W + CNT_W + 2;

   logic signed [SAMPLE_W-1:0] sample_mem [MAX_LEN];
   logic signed [WORK_W-1:0]   work_mem [WORK_LEN];
   logic signed [SAMPLE_W-1:0] srd_ff;
   logic signed [WORK_W-1:0]   wrd_ff;

   logic signed [SAMPLE_W-1:0] head_ff, head_in;
   logic signed [SAMPLE_W-1:0] tail_ff, tail_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [DELAY_W-1:0]  d0_ff, d0_in, d1_ff, d1_in;
   logic signed [WORK_W-1:0]   y_ff, y_in;
   logic signed [63:0]         p0_ff, p1_ff, p2_ff;
   logic signed [63:0]         p0_in, p1_in, p2_in;
   logic signed [63:0]         q1_ff, q2_ff, q1_in, q2_in;

   // restoring divider for the demean quotient
   logic signed [SUM_W+1:0]    num_ff, num_in;
   logic [SUM_W+1:0]           rem_ff, rem_in, quo_ff, quo_in;
   logic [SUM_W+1:0]           den;
   logic [5:0]                 dcnt_ff, dcnt_in;
   logic                       dneg_ff, dneg_in;
   logic                       ddone_ff, ddone_in;

   logic                       ovalid_ff, ovalid_in;
   logic signed [SAMPLE_W-1:0] odata_ff, odata_in;
   logic                       olast_ff, olast_in;
   logic                       oovf_ff, oovf_in;

   logic [SIDX_W-1:0]  sidx;
   logic [WIDX_W-1:0]  widx;
   logic               wwe;
   logic signed [WORK_W-1:0] wwd;

   function automatic logic signed [63:0] asr14(input logic signed [63:0] v);
      return v >>> PROD_SHIFT;
   endfunction

   assign sidx = cmd.index[SIDX_W-1:0];
   assign widx = cmd.aux[WIDX_W-1:0];
   assign den  = (SUM_W+2)'(2 * count);

   // memories
   always_ff @(posedge clock) begin
      if (cmd.op == OP_STORE) begin
         sample_mem[sidx] <= sample_in;
      end
      srd_ff <= sample_mem[sidx];
      if (wwe) begin
         work_mem[widx] <= wwd;
      end
      wrd_ff <= work_mem[widx];
   end

   always_comb begin
      head_in = head_ff; tail_in = tail_ff; sum_in = sum_ff;
      d0_in = d0_ff; d1_in = d1_ff; y_in = y_ff;
      p0_in = p0_ff; p1_in = p1_ff; p2_in = p2_ff; q1_in = q1_ff; q2_in = q2_ff;
      num_in = num_ff; rem_in = rem_ff; quo_in = quo_ff; dcnt_in = dcnt_ff;
      dneg_in = dneg_ff; ddone_in = 1'b0;
      ovalid_in = ovalid_ff && !rsp_tready;
      odata_in = odata_ff; olast_in = olast_ff; oovf_in = oovf_ff;
      wwe = 1'b0; wwd = wrd_ff;
      case (cmd.op)
         OP_SUM: begin
            // phase 0 accumulates the previous read, 1 takes the head, 2 the tail
            if (cmd.phase == 2'd0) begin
               if (cmd.first) sum_in = '0;
               else sum_in = sum_ff + SUM_W'(srd_ff);
            end
            if (cmd.phase == 2'd1) head_in = srd_ff;
            if (cmd.phase == 2'd2) tail_in = srd_ff;
         end
         OP_DIVIDE: begin
            if (cmd.first) begin
               num_in  = (SUM_W+2)'(2) * ((SUM_W+2)'(count) * (SUM_W+2)'(srd_ff)
                         - (SUM_W+2)'(sum_ff)) + (SUM_W+2)'(count);
               dcnt_in = 6'(SUM_W + 2);
               rem_in  = '0;
               quo_in  = '0;
            end else if (dcnt_ff != '0) begin
               logic [SUM_W+1:0] mag;
               logic [SUM_W+2:0] r;
               mag = num_ff[SUM_W+1] ? (SUM_W+2)'(-num_ff) : num_ff;
               dneg_in = num_ff[SUM_W+1];
               r = {rem_ff, mag[dcnt_ff-1]};
               if (r >= {1'b0, den}) begin
                  rem_in = (SUM_W+2)'(r - {1'b0, den});
                  quo_in = {quo_ff[SUM_W:0], 1'b1};
               end else begin
                  rem_in = r[SUM_W+1:0];
                  quo_in = {quo_ff[SUM_W:0], 1'b0};
               end
               dcnt_in = dcnt_ff - 6'd1;
               ddone_in = (dcnt_ff == 6'd1);
            end
         end
         OP_DEMEAN: begin
            logic signed [SUM_W+2:0] q;
            q = dneg_ff ? -$signed({1'b0, quo_ff})
                          - ((rem_ff != '0) ? (SUM_W+3)'(1) : (SUM_W+3)'(0))
                        : $signed({1'b0, quo_ff});
            ovalid_in = 1'b1;
            odata_in  = sat24(80'(q));
            olast_in  = cmd.last;
            oovf_in   = ovf;
         end
         OP_EXTEND: begin
            // phase 0: copy, 1: head reflect, 2: tail reflect
            wwe = 1'b1;
            case (cmd.phase)
               2'd1: wwd = WORK_W'(2 * 32'(head_ff) - 32'(srd_ff));
               2'd2: wwd = WORK_W'(2 * 32'(tail_ff) - 32'(srd_ff));
               default: wwd = WORK_W'(srd_ff);
            endcase
         end
         OP_INIT: begin
            if (cmd.phase == 2'd1) begin
               p0_in = regs[REG_ZI0] * 64'(wrd_ff);
               p1_in = regs[REG_ZI1] * 64'(wrd_ff);
            end else if (cmd.phase == 2'd2) begin
               d0_in = sat48(80'(asr14(p0_ff)));
               d1_in = sat48(80'(asr14(p1_ff)));
            end
         end
         OP_FILTER: begin
            unique case (cmd.phase)
               2'd0: begin
                  p0_in = regs[REG_B0] * 64'(wrd_ff);
                  p1_in = regs[REG_B1] * 64'(wrd_ff);
                  p2_in = regs[REG_B2] * 64'(wrd_ff);
               end
               2'd1: begin
                  logic signed [63:0] acc;
                  acc  = asr14(p0_ff) + 64'(d0_ff) + 64'sd32768;
                  y_in = sat32(80'(acc >>> FRAC_BITS));
               end
               2'd2: begin
                  q1_in = regs[REG_A1] * 64'(y_ff);
                  q2_in = regs[REG_A2] * 64'(y_ff);
               end
               2'd3: begin
                  d0_in = sat48(80'(asr14(p1_ff)) + 80'(d1_ff) - 80'(asr14(q1_ff)));
                  d1_in = sat48(80'(asr14(p2_ff)) - 80'(asr14(q2_ff)));
                  wwe = 1'b1;
                  wwd = y_ff;
               end
            endcase
         end
         OP_EMIT: begin
            ovalid_in = 1'b1;
            odata_in  = sat24(80'(wrd_ff));
            olast_in  = cmd.last;
            oovf_in   = ovf;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
         ddone_ff  <= 1'b0;
         dcnt_ff   <= '0;
      end else begin
         ovalid_ff <= ovalid_in;
         ddone_ff  <= ddone_in;
         dcnt_ff   <= dcnt_in;
      end
      head_ff <= head_in; tail_ff <= tail_in; sum_ff <= sum_in;
      d0_ff <= d0_in; d1_ff <= d1_in; y_ff <= y_in;
      p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in; q1_ff <= q1_in; q2_ff <= q2_in;
      num_ff <= num_in; rem_ff <= rem_in; quo_ff <= quo_in; dneg_ff <= dneg_in;
      odata_ff <= odata_in; olast_ff <= olast_in; oovf_ff <= oovf_in;
   end

   assign status.out_busy = ovalid_ff;
   assign status.div_done = ddone_ff;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = {oovf_ff, olast_ff};

endmodule

// ===== rtl/zpb_controller.sv =====
// -----------------------------------------------------------------------------
// zpb_controller
// sequencer for loading, summing, division and demean, extension, both filter passes and emission
// -----------------------------------------------------------------------------
module zpb_controller #(
   parameter int MAX_LEN = zpb_pkg::MAX_LEN_DEF,
   parameter int EDGE    = zpb_pkg::EDGE_DEF,
   parameter int CNT_W   = $clog2(MAX_LEN + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_last,
   output zpb_pkg::cmd_type     cmd,
   input  zpb_pkg::status_type  status,
   output logic [CNT_W-1:0]     count,
   output logic                 ovf,
   output logic                 busy
);
   import zpb_pkg::*;

   typedef enum logic [3:0] {
      ST_LOAD, ST_SUM, ST_DIV, ST_DEMEAN, ST_EXT, ST_INIT, ST_FILT, ST_EMIT, ST_DONE
   } state_type;

   state_type   state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic        ovf_ff, ovf_in;
   logic [12:0] i_ff, i_in;
   logic [1:0]  ph_ff, ph_in;
   logic        back_ff, back_in;
   logic        first_ff, first_in;
   logic        wait_ff, wait_in;
   cmd_type     c;
   logic [12:0] len;
   logic [12:0] n13;
   logic        acc;

   assign n13 = 13'(count_ff);
   assign len = n13 + 13'(2 * EDGE);
   assign acc = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_LOAD);

   always_comb begin
      state_in = state_ff; count_in = count_ff; ovf_in = ovf_ff;
      i_in = i_ff; ph_in = ph_ff; back_in = back_ff; first_in = 1'b0; wait_in = 1'b0;
      c = '0;
      c.op = OP_NONE;
      unique case (state_ff)
         ST_LOAD: begin
            if (acc) begin
               if (32'(count_ff) < MAX_LEN) begin
                  c.op = OP_STORE;
                  c.index = 13'(count_ff);
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last) begin
                  i_in = '0; ph_in = '0; first_in = 1'b1;
                  state_in = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            // read index i, accumulate previous read; then fetch head and tail
            c.op = OP_SUM; c.first = first_ff;
            if (ph_ff == 2'd0) begin
               c.phase = 2'd0;
               c.index = (i_ff < n13) ? i_ff : 13'd0;
               i_in = i_ff + 13'd1;
               if (i_ff == n13) ph_in = 2'd1;
            end else if (ph_ff == 2'd1) begin
               // head data arrives now, tail read issued
               c.phase = 2'd1;
               c.first = 1'b0;
               c.index = n13 - 13'd1;
               ph_in = 2'd2;
            end else begin
               // tail data arrives now
               c.phase = 2'd2;
               c.first = 1'b0;
               ph_in = 2'd0; i_in = '0; first_in = 1'b1;
               state_in = (32'(count_ff) <= EDGE) ? ST_DIV : ST_EXT;
            end
         end
         ST_DIV: begin
            c.op = OP_DIVIDE; c.index = i_ff; c.first = first_ff;
            if (ph_ff == 2'd0) begin
               c.op = OP_NONE; ph_in = 2'd1; first_in = 1'b1;
            end else if (status.div_done) begin
               ph_in = '0; state_in = ST_DEMEAN;
            end
         end
         ST_DEMEAN: begin
            if (!status.out_busy) begin
               c.op = OP_DEMEAN; c.last = (i_ff + 13'd1 == n13);
               i_in = i_ff + 13'd1;
               state_in = (i_ff + 13'd1 == n13) ? ST_DONE : ST_DIV;
            end
         end
         ST_EXT: begin
            // phase 0: issue read, 1: write one work entry
            if (ph_ff == 2'd0) begin
               if (i_ff < 13'(EDGE)) c.index = 13'(EDGE) - i_ff;
               else if (i_ff < 13'(2 * EDGE)) c.index = n13 - 13'd2 - (i_ff - 13'(EDGE));
               else c.index = i_ff - 13'(2 * EDGE);
               ph_in = 2'd1;
            end else begin
               c.op = OP_EXTEND;
               if (i_ff < 13'(EDGE)) begin
                  c.phase = 2'd1; c.aux = i_ff;
               end else if (i_ff < 13'(2 * EDGE)) begin
                  c.phase = 2'd2; c.aux = n13 + i_ff;
               end else begin
                  c.phase = 2'd0; c.aux = i_ff - 13'(EDGE);
               end
               ph_in = 2'd0;
               i_in = i_ff + 13'd1;
               if (i_ff + 13'd1 == len) begin
                  i_in = '0; back_in = 1'b0; state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            c.op = OP_INIT; c.phase = ph_ff;
            c.aux = back_ff ? len - 13'd1 : 13'd0;
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd2) begin
               ph_in = 2'd0; i_in = '0; wait_in = 1'b1; state_in = ST_FILT;
            end
         end
         ST_FILT: begin
            // read issued in previous cycle (wait) then four phases
            c.aux = back_ff ? len - 13'd1 - i_ff : i_ff;
            if (wait_ff) begin
               c.op = OP_NONE;
            end else begin
               c.op = OP_FILTER; c.phase = ph_ff;
               ph_in = ph_ff + 2'd1;
               if (ph_ff == 2'd3) begin
                  wait_in = 1'b1;
                  i_in = i_ff + 13'd1;
                  if (i_ff + 13'd1 == len) begin
                     i_in = '0; ph_in = '0; wait_in = 1'b0;
                     if (back_ff) begin
                        state_in = ST_EMIT; wait_in = 1'b1;
                     end else begin
                        back_in = 1'b1; state_in = ST_INIT;
                     end
                  end
               end
            end
            if (wait_ff) ph_in = '0;
         end
         ST_EMIT: begin
            c.aux = 13'(EDGE) + i_ff;
            if (wait_ff) begin
               c.op = OP_NONE;
            end else if (!status.out_busy) begin
               c.op = OP_EMIT; c.last = (i_ff + 13'd1 == n13);
               i_in = i_ff + 13'd1;
               wait_in = 1'b1;
               c.aux = 13'(EDGE) + i_ff + 13'd1;
               if (i_ff + 13'd1 == n13) state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            count_in = '0; ovf_in = 1'b0; state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; count_ff <= '0; ovf_ff <= 1'b0;
         i_ff <= '0; ph_ff <= '0; back_ff <= 1'b0; first_ff <= 1'b0; wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; ovf_ff <= ovf_in;
         i_ff <= i_in; ph_ff <= ph_in; back_ff <= back_in;
         first_ff <= first_in; wait_ff <= wait_in;
      end
   end

   assign cmd   = c;
   assign count = count_ff;
   assign ovf   = ovf_ff;
   assign busy  = (state_ff != ST_LOAD);

endmodule

// ===== rtl/zero_phase_biquad_filter.sv =====
// after the last request the block is summed and its first and last samples fetched;
// a block of up to EDGE samples is then demeaned, one serial division per result,
// a longer one is extended, filtered forward and backward, then emitted
// throughput: one request per cycle while loading, none taken until the block is done;
// a stalled result holds the sequencer
// reset: synchronous, clears counters, flags, state and coefficients to defaults
// -----------------------------------------------------------------------------
// zero_phase_biquad_filter
// forward-backward biquad over a block with odd reflection at both ends
// -----------------------------------------------------------------------------
`include "zero_phase_biquad_filter_macros.svh"
module zero_phase_biquad_filter #(
   parameter int MAX_LEN = zpb_pkg::MAX_LEN_DEF,
   parameter int EDGE    = zpb_pkg::EDGE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // sample_in
   input  logic        req_tlast,   // last_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // filtered
   output logic        rsp_tlast,   // last_out
   output logic        rsp_tuser,   // overflow
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import zpb_pkg::*;

   localparam int CNT_W = $clog2(MAX_LEN + 1);

   logic signed [COEF_W-1:0] regs_ff [NUM_REGS];
   logic [2:0]   reg_idx;
   logic         wr;
   cmd_type      cmd;
   status_type   status;
   logic [CNT_W-1:0] count;
   logic         ovf;
   logic         busy;
   logic [1:0]   tu;

   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[4:2];
   assign wr = csr_psel && csr_penable && csr_pwrite;

   // register file, defaults to a pass-through filter
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_REGS; k++)
            regs_ff[k] <= (k == int'(REG_B0)) ? 32'sh40000000 : 32'sh0;
      end else if (wr && 32'(reg_idx) < NUM_REGS) begin
         regs_ff[reg_idx] <= csr_pwdata;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (32'(reg_idx) < NUM_REGS) csr_prdata = regs_ff[reg_idx];
   end

   zpb_controller #(.MAX_LEN(MAX_LEN), .EDGE(EDGE)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_last(req_tlast),
      .cmd(cmd), .status(status), .count(count), .ovf(ovf), .busy(busy)
   );

   zpb_datapath #(.MAX_LEN(MAX_LEN), .EDGE(EDGE)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .sample_in(req_tdata), .count(count), .ovf(ovf), .regs(regs_ff),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(tu)
   );

   assign rsp_tlast = tu[0];
   assign rsp_tuser = tu[1];

   // no requests taken while a block is being processed
   `ZPB_ASSERT_IMPL(a_no_load_busy, clock, reset, busy, !req_tready, "ready while busy")
   // a waiting result stays valid until it is taken
   `ZPB_ASSERT_NEXT(a_rsp_busy, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result lost")

endmodule
